[hw/rtl/sclm_pkg.sv]
// ----------------------------------------------------------------------------
// sclm_pkg
// Shared types and constants of the sorted count-list merge-add block.
// ----------------------------------------------------------------------------
package sclm_pkg;

    localparam int LIST_DEPTH  = 1024;
    localparam int VERTEX_BITS = 32;
    localparam int COUNT_BITS  = 32;

    localparam int ADDR_BITS = $clog2(LIST_DEPTH);
    localparam int PTR_BITS  = $clog2(LIST_DEPTH + 1);

    localparam int FIELD_BITS = 32;
    localparam int DATA_BITS  = 3 * FIELD_BITS;
    localparam int SRC_LSB    = 0;
    localparam int DST_LSB    = FIELD_BITS;
    localparam int CNT_LSB    = 2 * FIELD_BITS;
    localparam int KIND_BITS  = 2;
    localparam int OUT_USER_BITS = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KIND_BITS-1:0] KIND_CLEAR    = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_APPEND_A = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_APPEND_B = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_PULL     = 2'd3;

    typedef logic [FIELD_BITS-1:0]  field_t;
    typedef logic [VERTEX_BITS-1:0] vertex_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [PTR_BITS-1:0]    ptr_t;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND_A,
        OP_APPEND_B,
        OP_PULL
    } op_t;

    typedef struct packed {
        vertex_t src;
        vertex_t dst;
        count_t  cnt;
    } entry_t;

    typedef struct packed {
        op_t    op;
        entry_t entry;
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_head_t;

endpackage

[hw/rtl/sorted_count_list_merge_add.sv]
// ----------------------------------------------------------------------------
// sorted_count_list_merge_add
// Two sorted (src, dst, count) lists merged on pull, equal keys summed.
//
// Channel  Dir  tdata (low bit up)              tuser / tlast
// s_axis   in   src_vertex, dst_vertex, count_in  tuser: kind
// m_axis   out  out_src, out_dst, out_count       tuser: is_empty, saturated,
//                                                 overflowed; tlast: is_last
//
// Clear and append update the list state in the engine; a pull does a list
// memory read, then key compare and count add into the output register.
// Requests wait in a four-deep queue, so s_axis keeps accepting while a
// pull result stalls on m_axis; a pull waits until the output register is free.
// Reset empties both lists and the queue; list memories are not cleared.
// ----------------------------------------------------------------------------
module sorted_count_list_merge_add (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // src_vertex, dst_vertex, count_in
    input  logic [sclm_pkg::DATA_BITS-1:0]      s_axis_tdata,
    // kind
    input  logic [sclm_pkg::KIND_BITS-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_src, out_dst, out_count
    output logic [sclm_pkg::DATA_BITS-1:0]      m_axis_tdata,
    // is_empty, saturated, overflowed
    output logic [sclm_pkg::OUT_USER_BITS-1:0]  m_axis_tuser,
    output logic                                m_axis_tlast
);

    sclm_pkg::q_head_t  head;
    logic               pop;
    sclm_pkg::entry_t   out_entry;
    logic               out_last;
    logic               out_empty;
    logic               out_sat;
    logic               out_ovf;

    sclm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .head          (head),
        .pop           (pop)
    );

    sclm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_entry (out_entry),
        .out_last  (out_last),
        .out_empty (out_empty),
        .out_sat   (out_sat),
        .out_ovf   (out_ovf)
    );

    assign m_axis_tdata = {sclm_pkg::field_t'(out_entry.cnt),
                           sclm_pkg::field_t'(out_entry.dst),
                           sclm_pkg::field_t'(out_entry.src)};
    assign m_axis_tuser = {out_ovf, out_sat, out_empty};
    assign m_axis_tlast = out_last;

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tlast
                                             && !m_axis_tuser[1])
        else $error("empty pull carries data");

    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |-> (out_entry.cnt == '1))
        else $error("saturated count not clamped");

    a_pop_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && (head.item.op == sclm_pkg::OP_PULL) |-> !m_axis_tvalid)
        else $error("pull started while result pending");

    a_pull_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && (head.item.op == sclm_pkg::OP_PULL) |=> ##1 m_axis_tvalid)
        else $error("pull gave no result");

endmodule

[hw/rtl/sclm_front.sv]
// ----------------------------------------------------------------------------
// sclm_front
// Accepts requests, decodes the kind and queues them for the merge engine.
// ----------------------------------------------------------------------------
module sclm_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sclm_pkg::DATA_BITS-1:0]      s_axis_tdata,
    input  logic [sclm_pkg::KIND_BITS-1:0]      s_axis_tuser,
    output sclm_pkg::q_head_t                   head,
    input  logic                                pop
);

    sclm_pkg::q_item_t                  q_mem_reg [sclm_pkg::QUEUE_DEPTH];
    logic [sclm_pkg::QPTR_BITS-1:0]     wr_ptr_reg;
    logic [sclm_pkg::QPTR_BITS-1:0]     rd_ptr_reg;
    logic [sclm_pkg::QCNT_BITS-1:0]     count_reg;
    logic [sclm_pkg::QCNT_BITS-1:0]     count_next;
    sclm_pkg::q_item_t                  in_item;
    logic                               push;
    logic                               do_pop;

    always_comb begin
        case (s_axis_tuser)
            sclm_pkg::KIND_CLEAR:    in_item.op = sclm_pkg::OP_CLEAR;
            sclm_pkg::KIND_APPEND_A: in_item.op = sclm_pkg::OP_APPEND_A;
            sclm_pkg::KIND_APPEND_B: in_item.op = sclm_pkg::OP_APPEND_B;
            sclm_pkg::KIND_PULL:     in_item.op = sclm_pkg::OP_PULL;
            default:                 in_item.op = sclm_pkg::OP_PULL;
        endcase
        in_item.entry.src = s_axis_tdata[sclm_pkg::SRC_LSB +: sclm_pkg::VERTEX_BITS];
        in_item.entry.dst = s_axis_tdata[sclm_pkg::DST_LSB +: sclm_pkg::VERTEX_BITS];
        in_item.entry.cnt = s_axis_tdata[sclm_pkg::CNT_LSB +: sclm_pkg::COUNT_BITS];
    end

    assign s_axis_tready = (count_reg != sclm_pkg::QCNT_BITS'(sclm_pkg::QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign do_pop        = pop && (count_reg != '0);

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = q_mem_reg[rd_ptr_reg];

endmodule

[hw/rtl/sclm_back.sv]
// ----------------------------------------------------------------------------
// sclm_back
// Holds both lists, executes queued requests and registers merged entries.
// ----------------------------------------------------------------------------
module sclm_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sclm_pkg::q_head_t       head,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output sclm_pkg::entry_t        out_entry,
    output logic                    out_last,
    output logic                    out_empty,
    output logic                    out_sat,
    output logic                    out_ovf
);

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } state_t;

    sclm_pkg::entry_t   mem_a [sclm_pkg::LIST_DEPTH];
    sclm_pkg::entry_t   mem_b [sclm_pkg::LIST_DEPTH];
    sclm_pkg::entry_t   rd_a_reg;
    sclm_pkg::entry_t   rd_b_reg;

    state_t             state_reg;
    sclm_pkg::ptr_t     len_a_reg;
    sclm_pkg::ptr_t     len_b_reg;
    sclm_pkg::ptr_t     rp_a_reg;
    sclm_pkg::ptr_t     rp_b_reg;
    sclm_pkg::ptr_t     rp_a_next;
    sclm_pkg::ptr_t     rp_b_next;
    logic               drop_reg;
    logic               out_valid_reg;
    sclm_pkg::entry_t   out_entry_reg;
    sclm_pkg::entry_t   res_entry;
    logic               out_last_reg;
    logic               out_empty_reg;
    logic               out_sat_reg;
    logic               out_ovf_reg;

    logic               full_a;
    logic               full_b;
    logic               wr_a;
    logic               wr_b;
    logic               have_a;
    logic               have_b;
    logic               key_lt;
    logic               key_eq;
    logic               take_a;
    logic               take_b;
    logic               both_eq;
    logic [sclm_pkg::COUNT_BITS:0] sum;
    logic               sat;

    assign full_a = (len_a_reg == sclm_pkg::PTR_BITS'(sclm_pkg::LIST_DEPTH));
    assign full_b = (len_b_reg == sclm_pkg::PTR_BITS'(sclm_pkg::LIST_DEPTH));

    assign pop = (state_reg == ST_IDLE) && head.valid
                 && ((head.item.op != sclm_pkg::OP_PULL) || !out_valid_reg);
    assign wr_a = pop && (head.item.op == sclm_pkg::OP_APPEND_A) && !full_a;
    assign wr_b = pop && (head.item.op == sclm_pkg::OP_APPEND_B) && !full_b;

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            mem_a[len_a_reg[sclm_pkg::ADDR_BITS-1:0]] <= head.item.entry;
        end
        if (wr_b) begin
            mem_b[len_b_reg[sclm_pkg::ADDR_BITS-1:0]] <= head.item.entry;
        end
        rd_a_reg <= mem_a[rp_a_reg[sclm_pkg::ADDR_BITS-1:0]];
        rd_b_reg <= mem_b[rp_b_reg[sclm_pkg::ADDR_BITS-1:0]];
    end

    always_comb begin
        have_a  = (rp_a_reg < len_a_reg);
        have_b  = (rp_b_reg < len_b_reg);
        key_lt  = (rd_a_reg.src < rd_b_reg.src)
                  || ((rd_a_reg.src == rd_b_reg.src) && (rd_a_reg.dst < rd_b_reg.dst));
        key_eq  = (rd_a_reg.src == rd_b_reg.src) && (rd_a_reg.dst == rd_b_reg.dst);
        take_a  = have_a && (!have_b || key_lt || key_eq);
        take_b  = have_b && (!have_a || !key_lt);
        both_eq = have_a && have_b && key_eq;
        sum     = {1'b0, rd_a_reg.cnt} + {1'b0, rd_b_reg.cnt};
        sat     = both_eq && sum[sclm_pkg::COUNT_BITS];
        rp_a_next = take_a ? rp_a_reg + 1'b1 : rp_a_reg;
        rp_b_next = take_b ? rp_b_reg + 1'b1 : rp_b_reg;
        if (!have_a && !have_b) begin
            res_entry = '0;
        end else if (take_a) begin
            res_entry = rd_a_reg;
        end else begin
            res_entry = rd_b_reg;
        end
        if (both_eq) begin
            res_entry.cnt = sat ? '1 : sum[sclm_pkg::COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_a_reg     <= '0;
            len_b_reg     <= '0;
            rp_a_reg      <= '0;
            rp_b_reg      <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        case (head.item.op)
                            sclm_pkg::OP_CLEAR: begin
                                len_a_reg <= '0;
                                len_b_reg <= '0;
                                rp_a_reg  <= '0;
                                rp_b_reg  <= '0;
                                drop_reg  <= 1'b0;
                            end
                            sclm_pkg::OP_APPEND_A: begin
                                if (full_a) begin
                                    drop_reg <= 1'b1;
                                end else begin
                                    len_a_reg <= len_a_reg + 1'b1;
                                end
                            end
                            sclm_pkg::OP_APPEND_B: begin
                                if (full_b) begin
                                    drop_reg <= 1'b1;
                                end else begin
                                    len_b_reg <= len_b_reg + 1'b1;
                                end
                            end
                            sclm_pkg::OP_PULL: begin
                                state_reg <= ST_EVAL;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_EVAL: begin
                    rp_a_reg      <= rp_a_next;
                    rp_b_reg      <= rp_b_next;
                    out_valid_reg <= 1'b1;
                    out_entry_reg <= res_entry;
                    out_empty_reg <= !have_a && !have_b;
                    out_last_reg  <= (have_a || have_b)
                                     && (rp_a_next >= len_a_reg) && (rp_b_next >= len_b_reg);
                    out_sat_reg   <= sat;
                    out_ovf_reg   <= drop_reg;
                    state_reg     <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_entry = out_entry_reg;
    assign out_last  = out_last_reg;
    assign out_empty = out_empty_reg;
    assign out_sat   = out_sat_reg;
    assign out_ovf   = out_ovf_reg;

endmodule
